// ===== src/psc_pkg.sv =====
// Character codes and verdict codes for the polynomial syntax checker.
package psc_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] VERDICT_OK  = 2'd0;
  localparam logic [1:0] VERDICT_ACC = 2'd1;
  localparam logic [1:0] VERDICT_REJ = 2'd2;

endpackage

// ===== src/polynomial_syntax_checker.sv =====
// Polynomial syntax checker: per-character automaton with a registered result stage.
//
// Each item on the input channel is one character of a text; a zero character ends
// the text. Every item yields exactly one result item, registered in the cycle after
// the item is taken: verdict 0 while the text is still well-formed, 2 once it is
// not (sticky until the end of the text), and at the terminator 1 (accepted) or 2
// (rejected), with last set. An empty text is rejected. The block takes one
// character per cycle; the single 4-bit state register and its one transition per
// character set that rate, and the input is stalled only while a result waits in
// the output register and the receiver stalls.
module polynomial_syntax_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  output logic       out_last
);

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_SIGN   = 4'd1,
    ST_POPEN  = 4'd2,
    ST_PNUM   = 4'd3,
    ST_PSLASH = 4'd4,
    ST_PDEN   = 4'd5,
    ST_CLOSE  = 4'd6,
    ST_NUM    = 4'd7,
    ST_SLASH  = 4'd8,
    ST_DEN    = 4'd9,
    ST_MUL    = 4'd10,
    ST_X      = 4'd11,
    ST_CARET  = 4'd12,
    ST_EXP    = 4'd13,
    ST_ERR    = 4'd14
  } state_t;

  state_t     state_r, state_nxt, trans;
  state_t     after_coef, term_start;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_verdict_r, out_verdict_nxt;
  logic       out_last_r, out_last_nxt;
  logic       accept, is_term, is_sign, is_lead, is_digit, may_end;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_term  = (in_ch == psc_pkg::CH_NUL);
  assign is_sign  = (in_ch == psc_pkg::CH_PLUS) || (in_ch == psc_pkg::CH_MINUS);
  assign is_lead  = (in_ch >= psc_pkg::CH_ONE) && (in_ch <= psc_pkg::CH_NINE);
  assign is_digit = (in_ch >= psc_pkg::CH_ZERO) && (in_ch <= psc_pkg::CH_NINE);
  assign may_end  = (state_r == ST_CLOSE) || (state_r == ST_NUM) || (state_r == ST_DEN) ||
                    (state_r == ST_X) || (state_r == ST_EXP);

  always_comb begin
    priority if (in_ch == psc_pkg::CH_STAR) after_coef = ST_MUL;
    else if (in_ch == psc_pkg::CH_X)        after_coef = ST_X;
    else if (is_sign)                       after_coef = ST_SIGN;
    else                                    after_coef = ST_ERR;

    priority if (in_ch == psc_pkg::CH_LPAR) term_start = ST_POPEN;
    else if (is_lead)                       term_start = ST_NUM;
    else if (in_ch == psc_pkg::CH_X)        term_start = ST_X;
    else                                    term_start = ST_ERR;
  end

  always_comb begin
    unique case (state_r)
      ST_START:  trans = is_sign ? ST_SIGN : term_start;
      ST_SIGN:   trans = term_start;
      ST_POPEN:  trans = is_lead ? ST_PNUM : ST_ERR;
      ST_PNUM: begin
        priority if (is_digit)                  trans = ST_PNUM;
        else if (in_ch == psc_pkg::CH_SLASH)    trans = ST_PSLASH;
        else if (in_ch == psc_pkg::CH_RPAR)     trans = ST_CLOSE;
        else                                    trans = ST_ERR;
      end
      ST_PSLASH: trans = is_lead ? ST_PDEN : ST_ERR;
      ST_PDEN: begin
        priority if (is_digit)                  trans = ST_PDEN;
        else if (in_ch == psc_pkg::CH_RPAR)     trans = ST_CLOSE;
        else                                    trans = ST_ERR;
      end
      ST_CLOSE:  trans = after_coef;
      ST_NUM: begin
        priority if (is_digit)                  trans = ST_NUM;
        else if (in_ch == psc_pkg::CH_SLASH)    trans = ST_SLASH;
        else                                    trans = after_coef;
      end
      ST_SLASH:  trans = is_lead ? ST_DEN : ST_ERR;
      ST_DEN:    trans = is_digit ? ST_DEN : after_coef;
      ST_MUL:    trans = (in_ch == psc_pkg::CH_X) ? ST_X : ST_ERR;
      ST_X: begin
        priority if (in_ch == psc_pkg::CH_CARET) trans = ST_CARET;
        else if (is_sign)                        trans = ST_SIGN;
        else                                     trans = ST_ERR;
      end
      ST_CARET:  trans = is_lead ? ST_EXP : ST_ERR;
      ST_EXP: begin
        priority if (is_digit)                  trans = ST_EXP;
        else if (is_sign)                       trans = ST_SIGN;
        else                                    trans = ST_ERR;
      end
      default:   trans = ST_ERR;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_verdict_nxt = out_verdict_r;
    out_last_nxt    = out_last_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (is_term) begin
        state_nxt       = ST_START;
        out_verdict_nxt = may_end ? psc_pkg::VERDICT_ACC : psc_pkg::VERDICT_REJ;
        out_last_nxt    = 1'b1;
      end else begin
        state_nxt       = trans;
        out_verdict_nxt = (trans == ST_ERR) ? psc_pkg::VERDICT_REJ : psc_pkg::VERDICT_OK;
        out_last_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_verdict_r <= out_verdict_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_term |=> state_r == ST_START)
    else $error("state not back at start after terminator");

  a_acc_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_verdict_r != psc_pkg::VERDICT_ACC)
    else $error("accept verdict on a non-terminator item");

  a_end_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_verdict_r != psc_pkg::VERDICT_OK)
    else $error("terminator item without a final verdict");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_term && state_r == ST_ERR |=> out_verdict_r == psc_pkg::VERDICT_REJ)
    else $error("error state did not stay rejected");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_verdict_r) && $stable(out_last_r))
    else $error("pending result lost while stalled");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for polynomial_syntax_checker: directed and random texts against a predictor.
module tb;

  typedef enum logic [3:0] {
    S_START, S_SIGN, S_POPEN, S_PNUM, S_PSLASH, S_PDEN, S_CLOSE, S_NUM,
    S_SLASH, S_DEN, S_MUL, S_X, S_CARET, S_EXP, S_ERR
  } parse_st_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
    result_t    res;
  } row_t;

  localparam int N_DIR    = 21;
  localparam int N_RANDOM = 1000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_ch     = psc_pkg::CH_NUL;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_verdict;
  logic       out_last;

  parse_st_t  pstate = S_START;
  result_t    verdict_q [$];
  logic [7:0] text_q [$];
  int         sent   = 0;
  int         errors = 0;
  logic       calm   = 1'b0;

  // typed rows: empty text, early terminator, leading zero, byte 0xFF, sticky error, accepted text
  row_t dir_rows [N_DIR] = '{
    {psc_pkg::CH_NUL,         1'b1, psc_pkg::VERDICT_REJ, 1'b1},
    {psc_pkg::CH_MINUS,       1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_LPAR,        1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_ONE,         1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_SLASH,       1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_ZERO + 8'd2, 1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_ZERO,        1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_RPAR,        1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_STAR,        1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_X,           1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_CARET,       1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_NINE,        1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_NUL,         1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_PLUS,        1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_NUL,         1'b1, psc_pkg::VERDICT_REJ, 1'b1},
    {psc_pkg::CH_ZERO,        1'b1, psc_pkg::VERDICT_REJ, 1'b0},
    {8'hFF,                   1'b1, psc_pkg::VERDICT_REJ, 1'b0},
    {psc_pkg::CH_NUL,         1'b1, psc_pkg::VERDICT_REJ, 1'b1},
    {psc_pkg::CH_ZERO + 8'd7, 1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_X,           1'b0, psc_pkg::VERDICT_OK,  1'b0},
    {psc_pkg::CH_NUL,         1'b1, psc_pkg::VERDICT_ACC, 1'b1}
  };

  polynomial_syntax_checker i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_ch       (in_ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic is_sign(logic [7:0] c);
    return c == psc_pkg::CH_PLUS || c == psc_pkg::CH_MINUS;
  endfunction

  function automatic logic is_lead(logic [7:0] c);
    return c >= psc_pkg::CH_ONE && c <= psc_pkg::CH_NINE;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= psc_pkg::CH_ZERO && c <= psc_pkg::CH_NINE;
  endfunction

  function automatic parse_st_t coef_tail(logic [7:0] c);
    if (c == psc_pkg::CH_STAR) return S_MUL;
    if (c == psc_pkg::CH_X) return S_X;
    if (is_sign(c)) return S_SIGN;
    return S_ERR;
  endfunction

  function automatic parse_st_t term_head(logic [7:0] c);
    if (c == psc_pkg::CH_LPAR) return S_POPEN;
    if (is_lead(c)) return S_NUM;
    if (c == psc_pkg::CH_X) return S_X;
    return S_ERR;
  endfunction

  function automatic parse_st_t advance(parse_st_t s, logic [7:0] c);
    case (s)
      S_START:  return is_sign(c) ? S_SIGN : term_head(c);
      S_SIGN:   return term_head(c);
      S_POPEN:  return is_lead(c) ? S_PNUM : S_ERR;
      S_PNUM: begin
        if (is_digit(c)) return S_PNUM;
        if (c == psc_pkg::CH_SLASH) return S_PSLASH;
        if (c == psc_pkg::CH_RPAR) return S_CLOSE;
        return S_ERR;
      end
      S_PSLASH: return is_lead(c) ? S_PDEN : S_ERR;
      S_PDEN: begin
        if (is_digit(c)) return S_PDEN;
        if (c == psc_pkg::CH_RPAR) return S_CLOSE;
        return S_ERR;
      end
      S_CLOSE:  return coef_tail(c);
      S_NUM: begin
        if (is_digit(c)) return S_NUM;
        if (c == psc_pkg::CH_SLASH) return S_SLASH;
        return coef_tail(c);
      end
      S_SLASH:  return is_lead(c) ? S_DEN : S_ERR;
      S_DEN:    return is_digit(c) ? S_DEN : coef_tail(c);
      S_MUL:    return c == psc_pkg::CH_X ? S_X : S_ERR;
      S_X: begin
        if (c == psc_pkg::CH_CARET) return S_CARET;
        if (is_sign(c)) return S_SIGN;
        return S_ERR;
      end
      S_CARET:  return is_lead(c) ? S_EXP : S_ERR;
      S_EXP: begin
        if (is_digit(c)) return S_EXP;
        if (is_sign(c)) return S_SIGN;
        return S_ERR;
      end
      default:  return S_ERR;
    endcase
  endfunction

  function automatic result_t next_verdict(logic [7:0] c);
    result_t r;
    if (c == psc_pkg::CH_NUL) begin
      r.verdict = (pstate inside {S_CLOSE, S_NUM, S_DEN, S_X, S_EXP}) ? psc_pkg::VERDICT_ACC
                                                                     : psc_pkg::VERDICT_REJ;
      r.last    = 1'b1;
      pstate    = S_START;
    end else begin
      pstate    = advance(pstate, c);
      r.verdict = (pstate == S_ERR) ? psc_pkg::VERDICT_REJ : psc_pkg::VERDICT_OK;
      r.last    = 1'b0;
    end
    return r;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fixed, input result_t typed);
    result_t r;
    calm = (sent >= 300 && sent < 500);
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = next_verdict(c);
    verdict_q.push_back(fixed ? typed : r);
    sent++;
  endtask

  task automatic add_number();
    int n;
    n = $urandom_range(3);
    text_q.push_back(psc_pkg::CH_ONE + 8'($urandom_range(8)));
    repeat (n) text_q.push_back(psc_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_poly();
    int terms;
    int kind;
    int tail;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0 || $urandom_range(1))
        text_q.push_back($urandom_range(1) ? psc_pkg::CH_PLUS : psc_pkg::CH_MINUS);
      kind = $urandom_range(4);
      tail = 0;
      if (kind == 0) begin
        text_q.push_back(psc_pkg::CH_X);
      end else begin
        if (kind >= 3) text_q.push_back(psc_pkg::CH_LPAR);
        add_number();
        if (kind == 2 || kind == 4) begin
          text_q.push_back(psc_pkg::CH_SLASH);
          add_number();
        end
        if (kind >= 3) text_q.push_back(psc_pkg::CH_RPAR);
        tail = $urandom_range(2);
        if (tail == 2) text_q.push_back(psc_pkg::CH_STAR);
        if (tail > 0) text_q.push_back(psc_pkg::CH_X);
      end
      if ((kind == 0 || tail > 0) && $urandom_range(1)) begin
        text_q.push_back(psc_pkg::CH_CARET);
        add_number();
      end
    end
    text_q.push_back(psc_pkg::CH_NUL);
  endtask

  task automatic break_poly();
    int idx;
    idx = $urandom_range(text_q.size() - 2);
    case ($urandom_range(2))
      0: text_q[idx] = 8'($urandom_range(1, 255));
      1: begin
        text_q = text_q[0:idx];
        text_q.push_back(psc_pkg::CH_NUL);
      end
      default: text_q.insert(idx, 8'($urandom_range(1, 255)));
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: verdict=%0d last=%0b", out_verdict, out_last);
      end else begin
        want = verdict_q.pop_front();
        if (out_verdict !== want.verdict || out_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected verdict=%0d last=%0b, got verdict=%0d last=%0b",
                     want.verdict, want.last, out_verdict, out_last);
        end
      end
    end
  end

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].res);
    while (sent < N_DIR + N_RANDOM) begin
      text_q.delete();
      pick = $urandom_range(99);
      if (pick < 90) begin
        add_poly();
        if (pick >= 70) break_poly();
      end else begin
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
        text_q.push_back(psc_pkg::CH_NUL);
      end
      foreach (text_q[i]) send_char(text_q[i], 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/psc_pkg.sv
src/polynomial_syntax_checker.sv
bench/tb.sv
